@@ rtl/cone_lane_steering_angle_core_macros.svh @@
// ---------------------------------------------------------------------------
// Cone lane steering angle: assertion macros
// Concurrent checks on a clock with a synchronous active-high reset.
// ---------------------------------------------------------------------------
`ifndef CONE_LANE_STEERING_ANGLE_CORE_MACROS_SVH
`define CONE_LANE_STEERING_ANGLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CLSA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define CLSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define CLSA_ASSERT_SAME(label, clk, rst, ante, cons)

`define CLSA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/clsa_pkg.sv @@
// ---------------------------------------------------------------------------
// Cone lane steering angle: package
// Shared constants, codes, sideband type and arctangent table.
// ---------------------------------------------------------------------------
package clsa_pkg;

  localparam int COORD_WIDTH_DEF  = 10;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int PRE_SHIFT        = 14;
  localparam int ZW               = 24;
  localparam int TABLE_LEN        = 24;

  localparam int MAG_W            = 23;
  localparam int NUM_W            = 38;
  localparam int T_SHIFT          = 17;
  localparam int T_W              = NUM_W - T_SHIFT;
  localparam int RECIP_W          = 22;
  localparam int RECIP_SHIFT      = 27;
  localparam int PROD_W           = T_W + RECIP_W;
  localparam int Q_W              = 15;

  localparam logic [MAG_W-1:0]   ANG_90   = 23'd5898240;
  localparam logic [NUM_W-1:0]   ANG_HALF = 38'd2949120;
  localparam logic [RECIP_W-1:0] RECIP_45 = 22'd2982617;

  localparam logic [1:0] OUT_CONES = 2'd0;
  localparam logic [1:0] OUT_HELD  = 2'd1;
  localparam logic [1:0] OUT_RANGE = 2'd2;

  localparam logic [1:0] REG_MAX_STEERING = 2'd0;
  localparam logic [1:0] REG_DIST_THRESH  = 2'd1;
  localparam logic [1:0] REG_CENTER_X     = 2'd2;

  typedef struct packed {
    logic              ax0;
    logic              ay0;
    logic              dxneg;
    logic [1:0]        outcome;
    logic signed [15:0] value;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (idx)
      0:  r = 24'sd2949120;
      1:  r = 24'sd1740967;
      2:  r = 24'sd919879;
      3:  r = 24'sd466945;
      4:  r = 24'sd234379;
      5:  r = 24'sd117304;
      6:  r = 24'sd58666;
      7:  r = 24'sd29335;
      8:  r = 24'sd14668;
      9:  r = 24'sd7334;
      10: r = 24'sd3667;
      11: r = 24'sd1833;
      12: r = 24'sd917;
      13: r = 24'sd458;
      14: r = 24'sd229;
      15: r = 24'sd115;
      16: r = 24'sd57;
      17: r = 24'sd29;
      18: r = 24'sd14;
      19: r = 24'sd7;
      20: r = 24'sd4;
      21: r = 24'sd2;
      22: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/cone_lane_steering_angle_core.sv @@
// ---------------------------------------------------------------------------
// Cone lane steering angle core
// Steering command from a blue and a yellow cone pair via a pipelined CORDIC.
// ---------------------------------------------------------------------------
// One item is accepted per clock while in_stall is low, and one result leaves
// per clock while out_stall is low. An item passes through CORDIC_STEPS + 6
// registers: two front stages (pair check and choice, direction vector),
// one stage per CORDIC rotation, three back stages (angle fold, scale
// multiply, divide by ninety degrees as a reciprocal multiply) and the
// output register. The output register is backed by a one-item skid buffer,
// which fills only when the output is stalled with a result arriving behind
// it; in_stall is high while that buffer holds an item, including the cycle
// in which it drains.
// Registers are written through the cfg port and must only change while the
// block is idle.
`include "cone_lane_steering_angle_core_macros.svh"

module cone_lane_steering_angle_core import clsa_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] blue_near_x,
  input  logic [COORD_WIDTH-1:0] blue_near_y,
  input  logic [COORD_WIDTH-1:0] blue_far_x,
  input  logic [COORD_WIDTH-1:0] blue_far_y,
  input  logic [COORD_WIDTH-1:0] yellow_near_x,
  input  logic [COORD_WIDTH-1:0] yellow_near_y,
  input  logic [COORD_WIDTH-1:0] yellow_far_x,
  input  logic [COORD_WIDTH-1:0] yellow_far_y,
  input  logic [15:0]            range_reading,
  input  logic signed [15:0]     previous_steering,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     steering_value,
  output logic [1:0]             outcome,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int XW = COORD_WIDTH + PRE_SHIFT + 3;
  localparam int P  = CORDIC_STEPS + 5;

  logic [14:0]          max_steering;
  logic [15:0]          distance_threshold;
  logic [9:0]           image_center_x;

  logic                 en;
  logic                 skid_full;
  logic [P-1:0]         v;

  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  side_t                cs [CORDIC_STEPS+1];

  assign cfg_ready = 1'b1;
  assign en        = !skid_full;
  assign in_stall  = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steering       <= 15'd7680;
      distance_threshold <= 16'd65535;
      image_center_x     <= 10'd320;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_STEERING: max_steering       <= cfg_data[14:0];
        REG_DIST_THRESH:  distance_threshold <= cfg_data;
        REG_CENTER_X:     image_center_x     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[P-2:0], in_valid};
    end
  end

  clsa_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk                (clk),
    .en                 (en),
    .blue_near_x        (blue_near_x),
    .blue_near_y        (blue_near_y),
    .blue_far_x         (blue_far_x),
    .blue_far_y         (blue_far_y),
    .yellow_near_x      (yellow_near_x),
    .yellow_near_y      (yellow_near_y),
    .yellow_far_x       (yellow_far_x),
    .yellow_far_y       (yellow_far_y),
    .range_reading      (range_reading),
    .previous_steering  (previous_steering),
    .distance_threshold (distance_threshold),
    .image_center_x     (image_center_x),
    .x0                 (cx[0]),
    .y0                 (cy[0]),
    .side0              (cs[0])
  );

  assign cz[0] = '0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    clsa_cordic_stage #(
      .XW   (XW),
      .STEP (g)
    ) u_stage (
      .clk      (clk),
      .en       (en),
      .x_in     (cx[g]),
      .y_in     (cy[g]),
      .z_in     (cz[g]),
      .side_in  (cs[g]),
      .x_out    (cx[g+1]),
      .y_out    (cy[g+1]),
      .z_out    (cz[g+1]),
      .side_out (cs[g+1])
    );
  end

  clsa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .v_last         (v[P-1]),
    .z_in           (cz[CORDIC_STEPS]),
    .side_in        (cs[CORDIC_STEPS]),
    .max_steering   (max_steering),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .skid_full      (skid_full),
    .steering_value (steering_value),
    .outcome        (outcome)
  );

  `CLSA_ASSERT_SAME(a_skid_implies_out, clk, rst, in_stall, out_valid)
  `CLSA_ASSERT_NEXT(a_stall_holds, clk, rst, in_stall && out_stall, in_stall)
  `CLSA_ASSERT_SAME(a_range_zero, clk, rst, out_valid && outcome == OUT_RANGE, steering_value == '0)
  `CLSA_ASSERT_NEXT(a_take_empties_skid, clk, rst, in_stall && !out_stall, !in_stall && out_valid)

endmodule

@@ rtl/clsa_front.sv @@
// ---------------------------------------------------------------------------
// Cone lane steering angle: front end
// Pair validity, pair choice and direction vector, over two stages.
// ---------------------------------------------------------------------------
module clsa_front import clsa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [COORD_WIDTH-1:0]                 blue_near_x,
  input  logic [COORD_WIDTH-1:0]                 blue_near_y,
  input  logic [COORD_WIDTH-1:0]                 blue_far_x,
  input  logic [COORD_WIDTH-1:0]                 blue_far_y,
  input  logic [COORD_WIDTH-1:0]                 yellow_near_x,
  input  logic [COORD_WIDTH-1:0]                 yellow_near_y,
  input  logic [COORD_WIDTH-1:0]                 yellow_far_x,
  input  logic [COORD_WIDTH-1:0]                 yellow_far_y,
  input  logic [15:0]                            range_reading,
  input  logic signed [15:0]                     previous_steering,
  input  logic [15:0]                            distance_threshold,
  input  logic [9:0]                             image_center_x,
  output logic signed [COORD_WIDTH+PRE_SHIFT+2:0] x0,
  output logic signed [COORD_WIDTH+PRE_SHIFT+2:0] y0,
  output side_t                                  side0
);

  localparam int W = COORD_WIDTH;

  logic [W-1:0]        ctr;
  logic                bv;
  logic                yv;
  logic                forced;
  logic                use_yellow;
  logic signed [W:0]   db_diff;
  logic signed [W:0]   dy_diff;
  logic [W-1:0]        db;
  logic [W-1:0]        dyl;
  side_t               side_a_next;

  logic [W-1:0]        a_nx;
  logic [W-1:0]        a_ny;
  logic [W-1:0]        a_fx;
  logic [W-1:0]        a_fy;
  side_t               a_side;

  logic signed [W:0]   dx;
  logic signed [W:0]   dy;
  logic [W-1:0]        ax;
  logic [W-1:0]        ay;
  side_t               side_b_next;

  always_comb begin
    ctr = W'(image_center_x);
    bv  = !(blue_near_x == '0 && blue_near_y == '0) &&
          !(blue_far_x == '0 && blue_far_y == '0) &&
          !(blue_near_x == blue_far_x && blue_near_y == blue_far_y);
    yv  = !(yellow_near_x == '0 && yellow_near_y == '0) &&
          !(yellow_far_x == '0 && yellow_far_y == '0) &&
          !(yellow_near_x == yellow_far_x && yellow_near_y == yellow_far_y);
    db_diff = $signed({1'b0, ctr}) - $signed({1'b0, blue_far_x});
    dy_diff = $signed({1'b0, yellow_far_x}) - $signed({1'b0, ctr});
    db  = db_diff[W] ? W'(-db_diff) : W'(db_diff);
    dyl = dy_diff[W] ? W'(-dy_diff) : W'(dy_diff);
    use_yellow = (bv && yv) ? (dyl < db) : yv;
    forced = (range_reading >= distance_threshold);

    side_a_next.ax0   = 1'b0;
    side_a_next.ay0   = 1'b0;
    side_a_next.dxneg = 1'b0;
    priority if (forced) begin
      side_a_next.outcome = OUT_RANGE;
      side_a_next.value   = '0;
    end else if (!bv && !yv) begin
      side_a_next.outcome = OUT_HELD;
      side_a_next.value   = previous_steering;
    end else begin
      side_a_next.outcome = OUT_CONES;
      side_a_next.value   = previous_steering;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_nx   <= use_yellow ? yellow_near_x : blue_near_x;
      a_ny   <= use_yellow ? yellow_near_y : blue_near_y;
      a_fx   <= use_yellow ? yellow_far_x  : blue_far_x;
      a_fy   <= use_yellow ? yellow_far_y  : blue_far_y;
      a_side <= side_a_next;
    end
  end

  always_comb begin
    dx = $signed({1'b0, a_fx}) - $signed({1'b0, a_nx});
    dy = $signed({1'b0, a_fy}) - $signed({1'b0, a_ny});
    ax = dx[W] ? W'(-dx) : W'(dx);
    ay = dy[W] ? W'(-dy) : W'(dy);
    side_b_next       = a_side;
    side_b_next.ax0   = (ax == '0);
    side_b_next.ay0   = (ay == '0);
    side_b_next.dxneg = dx[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0    <= $signed({3'b000, ax, {PRE_SHIFT{1'b0}}});
      y0    <= $signed({3'b000, ay, {PRE_SHIFT{1'b0}}});
      side0 <= side_b_next;
    end
  end

endmodule

@@ rtl/clsa_cordic_stage.sv @@
// ---------------------------------------------------------------------------
// Cone lane steering angle: CORDIC stage
// One registered vectoring rotation with a fixed shift and table angle.
// ---------------------------------------------------------------------------
module clsa_cordic_stage import clsa_pkg::*; #(
  parameter int XW   = COORD_WIDTH_DEF + PRE_SHIFT + 3,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  side_t                side_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output side_t                side_out
);

  localparam logic signed [ZW-1:0] ATAN = atan_val(STEP);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[XW-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end
      side_out <= side_in;
    end
  end

endmodule

@@ rtl/clsa_back.sv @@
// ---------------------------------------------------------------------------
// Cone lane steering angle: back end
// Angle fold, steering scale, divide by ninety degrees, output skid buffer.
// ---------------------------------------------------------------------------
module clsa_back import clsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_last,
  input  logic signed [ZW-1:0] z_in,
  input  side_t                side_in,
  input  logic [14:0]          max_steering,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 skid_full,
  output logic signed [15:0]   steering_value,
  output logic [1:0]           outcome
);

  logic [MAG_W-1:0]     zc;
  logic [MAG_W-1:0]     mag_next;
  logic                 neg_next;

  logic [MAG_W-1:0]     b1_mag;
  logic                 b1_neg;
  side_t                b1_side;
  logic [NUM_W-1:0]     b2_num;
  logic                 b2_neg;
  side_t                b2_side;
  logic [PROD_W-1:0]    b3_prod;
  logic                 b3_neg;
  side_t                b3_side;

  logic [Q_W-1:0]       q;
  logic signed [15:0]   res_value;
  logic signed [15:0]   skid_value;
  logic [1:0]           skid_outcome;
  logic                 take;

  always_comb begin
    priority if (z_in[ZW-1]) begin
      zc = '0;
    end else if (z_in > $signed({1'b0, ANG_90})) begin
      zc = ANG_90;
    end else begin
      zc = z_in[MAG_W-1:0];
    end
    priority if (side_in.ay0) begin
      mag_next = ANG_90;
      neg_next = !side_in.dxneg;
    end else if (side_in.ax0) begin
      mag_next = '0;
      neg_next = 1'b0;
    end else begin
      mag_next = ANG_90 - zc;
      neg_next = !side_in.dxneg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_mag  <= mag_next;
      b1_neg  <= neg_next;
      b1_side <= side_in;
      b2_num  <= b1_mag * max_steering + ANG_HALF;
      b2_neg  <= b1_neg;
      b2_side <= b1_side;
      b3_prod <= b2_num[NUM_W-1:T_SHIFT] * RECIP_45;
      b3_neg  <= b2_neg;
      b3_side <= b2_side;
    end
  end

  always_comb begin
    q = b3_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    if (b3_side.outcome == OUT_CONES) begin
      res_value = b3_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end else begin
      res_value = b3_side.value;
    end
  end

  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (v_last) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        steering_value <= skid_value;
        outcome        <= skid_outcome;
      end
    end else if (v_last) begin
      if (!out_valid || take) begin
        steering_value <= res_value;
        outcome        <= b3_side.outcome;
      end else begin
        skid_value   <= res_value;
        skid_outcome <= b3_side.outcome;
      end
    end
  end

endmodule

@@ tb/tb_cone_lane_steering_angle_core.sv @@
// ---------------------------------------------------------------------------
// Cone lane steering angle core: self-checking testbench
// Drives cone pair items with random idle and output stall bursts, predicts
// each steering result (cone results with a vectoring CORDIC of its own), and
// compares every result in order. Registers are reprogrammed between phases.
// ---------------------------------------------------------------------------
module tb_cone_lane_steering_angle_core;
  import clsa_pkg::*;

  localparam int CW           = COORD_WIDTH_DEF;
  localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
  localparam int ROTATIONS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int LATENCY      = CORDIC_STEPS + 6;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int VEC_SHIFT    = 14;

  localparam longint QUARTER_TURN = 64'd5898240;
  localparam longint HALF_TURN    = 64'd11796480;
  localparam longint ARCTAN [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [CW-1:0]      blue_near_x;
    logic [CW-1:0]      blue_near_y;
    logic [CW-1:0]      blue_far_x;
    logic [CW-1:0]      blue_far_y;
    logic [CW-1:0]      yellow_near_x;
    logic [CW-1:0]      yellow_near_y;
    logic [CW-1:0]      yellow_far_x;
    logic [CW-1:0]      yellow_far_y;
    logic [15:0]        range_reading;
    logic signed [15:0] previous_steering;
  } cone_item_t;

  typedef struct {
    logic signed [15:0] value;
    logic [1:0]         outcome;
  } steer_result_t;

  class steer_scoreboard;
    logic [14:0]   max_steering;
    logic [15:0]   dist_limit;
    logic [CW-1:0] centre_x;
    steer_result_t expected_q[$];
    int unsigned   mismatches;

    function new();
      max_steering = 15'd7680;
      dist_limit   = 16'd65535;
      centre_x     = 10'd320;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_MAX_STEERING: max_steering = data[14:0];
        REG_DIST_THRESH:  dist_limit = data;
        REG_CENTER_X:     centre_x = data[CW-1:0];
        default: ;
      endcase
    endfunction

    function bit pair_ok(logic [CW-1:0] nx, ny, fx, fy);
      if (nx == 0 && ny == 0) return 1'b0;
      if (fx == 0 && fy == 0) return 1'b0;
      if (nx == fx && ny == fy) return 1'b0;
      return 1'b1;
    endfunction

    function longint heading(longint dx, longint dy);
      longint ax, ay, x, y, z, xs, ys;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ay == 0) return (dx > 0) ? 64'd0 : HALF_TURN;
      if (ax == 0) return QUARTER_TURN;
      x = ax <<< VEC_SHIFT;
      y = ay <<< VEC_SHIFT;
      z = 0;
      for (int i = 0; i < ROTATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN[i];
        end
      end
      if (z < 0) z = 0;
      if (z > QUARTER_TURN) z = QUARTER_TURN;
      return (dx < 0) ? HALF_TURN - z : z;
    endfunction

    function void note_item(cone_item_t it);
      steer_result_t r;
      bit bv, yv, use_yellow;
      longint dyel, dblu, dx, dy, diff, mag, q;
      if (it.range_reading >= dist_limit) begin
        r.value   = 16'sd0;
        r.outcome = OUT_RANGE;
        expected_q.push_back(r);
        return;
      end
      bv = pair_ok(it.blue_near_x, it.blue_near_y, it.blue_far_x, it.blue_far_y);
      yv = pair_ok(it.yellow_near_x, it.yellow_near_y, it.yellow_far_x, it.yellow_far_y);
      if (!bv && !yv) begin
        r.value   = it.previous_steering;
        r.outcome = OUT_HELD;
        expected_q.push_back(r);
        return;
      end
      if (bv && yv) begin
        dyel = longint'(it.yellow_far_x) - longint'(centre_x);
        dblu = longint'(centre_x) - longint'(it.blue_far_x);
        if (dyel < 0) dyel = -dyel;
        if (dblu < 0) dblu = -dblu;
        use_yellow = (dyel < dblu);
      end else begin
        use_yellow = yv;
      end
      if (use_yellow) begin
        dx = longint'(it.yellow_far_x) - longint'(it.yellow_near_x);
        dy = longint'(it.yellow_far_y) - longint'(it.yellow_near_y);
      end else begin
        dx = longint'(it.blue_far_x) - longint'(it.blue_near_x);
        dy = longint'(it.blue_far_y) - longint'(it.blue_near_y);
      end
      diff = heading(dx, dy) - QUARTER_TURN;
      mag  = (diff < 0) ? -diff : diff;
      q    = (mag * longint'(max_steering) + QUARTER_TURN / 2) / QUARTER_TURN;
      q    = (diff < 0) ? -q : q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.value   = q[15:0];
      r.outcome = OUT_CONES;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] value, logic [1:0] oc);
      steer_result_t r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: steering %0d outcome %0d", value, oc);
        return;
      end
      r = expected_q.pop_front();
      if (value !== r.value || oc !== r.outcome) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: steering expected %0d got %0d, outcome expected %0d got %0d",
                   r.value, value, r.outcome, oc);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CW-1:0]      blue_near_x = '0;
  logic [CW-1:0]      blue_near_y = '0;
  logic [CW-1:0]      blue_far_x = '0;
  logic [CW-1:0]      blue_far_y = '0;
  logic [CW-1:0]      yellow_near_x = '0;
  logic [CW-1:0]      yellow_near_y = '0;
  logic [CW-1:0]      yellow_far_x = '0;
  logic [CW-1:0]      yellow_far_y = '0;
  logic [15:0]        range_reading = '0;
  logic signed [15:0] previous_steering = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] steering_value;
  logic [1:0]         outcome;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  steer_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int              stall_pct = 0;
  int              idle_pct = 0;
  int              stall_left = 0;

  cone_lane_steering_angle_core DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_cone_lane_steering_angle_core NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(steering_value, outcome);
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic cone_item_t cones(int bnx, bny, bfx, bfy, ynx, yny, yfx, yfy,
                                       int range_val, int prev);
    cone_item_t it;
    it.blue_near_x       = CW'(bnx);
    it.blue_near_y       = CW'(bny);
    it.blue_far_x        = CW'(bfx);
    it.blue_far_y        = CW'(bfy);
    it.yellow_near_x     = CW'(ynx);
    it.yellow_near_y     = CW'(yny);
    it.yellow_far_x      = CW'(yfx);
    it.yellow_far_y      = CW'(yfy);
    it.range_reading     = 16'(range_val);
    it.previous_steering = 16'(prev);
    return it;
  endfunction

  function automatic cone_item_t random_item(logic [15:0] limit, logic [CW-1:0] centre);
    cone_item_t it;
    int kind, pick, mirror;
    it = cones($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023), 0, $urandom);
    kind = $urandom_range(0, 23);
    case (kind)
      0: begin
        it.blue_near_x = '0;
        it.blue_near_y = '0;
      end
      1: begin
        it.blue_far_x = '0;
        it.blue_far_y = '0;
      end
      2: begin
        it.yellow_near_x = '0;
        it.yellow_near_y = '0;
      end
      3: begin
        it.yellow_far_x = '0;
        it.yellow_far_y = '0;
      end
      4: it = cones(0, 0, 0, 0, 0, 0, 0, 0, 0, $urandom);
      5: begin
        it.blue_far_x = it.blue_near_x;
        it.blue_far_y = it.blue_near_y;
      end
      6: begin
        it.yellow_far_x = it.yellow_near_x;
        it.yellow_far_y = it.yellow_near_y;
      end
      7: it.blue_far_y = it.blue_near_y;
      8: it.yellow_far_x = it.yellow_near_x;
      9: begin
        mirror = 2 * int'(centre) - int'(it.blue_far_x);
        if (mirror >= 0 && mirror <= 1023)
          it.yellow_far_x = CW'(mirror);
        else
          it.yellow_far_x = it.blue_far_x;
      end
      10: begin
        it.blue_far_x = CW'(int'(it.blue_near_x) + $urandom_range(0, 4) - 2);
        it.blue_far_y = CW'(int'(it.blue_near_y) + $urandom_range(0, 4) - 2);
      end
      11: begin
        it.yellow_far_x = CW'(int'(it.yellow_near_x) + $urandom_range(0, 4) - 2);
        it.yellow_far_y = CW'(int'(it.yellow_near_y) + $urandom_range(0, 4) - 2);
      end
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (limit == 0 || pick < 8)
      it.range_reading = 16'($urandom);
    else if (pick < 12)
      it.range_reading = limit;
    else
      it.range_reading = 16'($urandom_range(0, int'(limit) - 1));
    return it;
  endfunction

  task automatic send_item(input cone_item_t it);
    in_valid          <= 1'b1;
    blue_near_x       <= it.blue_near_x;
    blue_near_y       <= it.blue_near_y;
    blue_far_x        <= it.blue_far_x;
    blue_far_y        <= it.blue_far_y;
    yellow_near_x     <= it.yellow_near_x;
    yellow_near_y     <= it.yellow_near_y;
    yellow_far_x      <= it.yellow_far_x;
    yellow_far_y      <= it.yellow_far_y;
    range_reading     <= it.range_reading;
    previous_steering <= it.previous_steering;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic send_with_gaps(input cone_item_t it);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_item(it);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input logic [15:0] ms, dt, cx, input bit with_unused);
    if (with_unused) put_reg(REG_UNUSED, 16'($urandom));
    put_reg(REG_MAX_STEERING, ms);
    put_reg(REG_DIST_THRESH, dt);
    put_reg(REG_CENTER_X, cx);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    cone_item_t dir_q[$];
    dir_q.push_back(cones(100, 400, 200, 100, 500, 400, 400, 100, 65535, 1234));
    dir_q.push_back(cones(0, 0, 0, 0, 0, 0, 0, 0, 65534, -32768));
    dir_q.push_back(cones(0, 0, 0, 0, 0, 0, 0, 0, 0, 32767));
    dir_q.push_back(cones(0, 0, 300, 100, 600, 500, 500, 100, 10, 0));
    dir_q.push_back(cones(100, 500, 0, 0, 600, 500, 700, 100, 10, 0));
    dir_q.push_back(cones(100, 500, 200, 100, 0, 0, 500, 100, 10, 0));
    dir_q.push_back(cones(100, 500, 200, 100, 600, 500, 0, 0, 10, 0));
    dir_q.push_back(cones(123, 456, 123, 456, 789, 12, 789, 12, 10, -77));
    dir_q.push_back(cones(123, 456, 123, 456, 600, 500, 500, 100, 10, -77));
    dir_q.push_back(cones(10, 200, 1023, 200, 0, 0, 0, 0, 20, 5));
    dir_q.push_back(cones(1023, 200, 1, 200, 0, 0, 0, 0, 20, 5));
    dir_q.push_back(cones(320, 1023, 320, 1, 0, 0, 0, 0, 20, 5));
    dir_q.push_back(cones(0, 0, 0, 0, 320, 1, 320, 1023, 20, 5));
    dir_q.push_back(cones(200, 500, 300, 100, 400, 500, 340, 100, 30, 0));
    dir_q.push_back(cones(200, 500, 100, 100, 400, 500, 330, 100, 30, 0));
    dir_q.push_back(cones(200, 500, 319, 100, 400, 500, 1023, 100, 30, 0));
    dir_q.push_back(cones(1023, 1023, 1, 1, 0, 0, 0, 0, 40, 0));
    dir_q.push_back(cones(1, 1, 1023, 1023, 0, 0, 0, 0, 40, 0));
    dir_q.push_back(cones(512, 512, 513, 511, 0, 0, 0, 0, 40, 0));
    dir_q.push_back(cones(0, 0, 0, 0, 512, 512, 511, 513, 40, 0));
    dir_q.push_back(cones(1023, 0, 0, 1023, 0, 1023, 1023, 0, 0, 0));
    dir_q.push_back(cones(0, 5, 7, 0, 1023, 1023, 1023, 1022, 65534, 0));
    foreach (dir_q[i]) send_with_gaps(dir_q[i]);
  endtask

  initial begin
    int count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct  = 20;
    stall_pct = 15;
    run_directed();
    for (int p = 0; p < 8; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (p)
        0: ;
        1: program_regs(16'hFFFF, 16'd40000, 16'd0, 1'b0);
        2: program_regs(16'd0, 16'd0, 16'd1023, 1'b0);
        3: program_regs(16'($urandom), 16'hFFFF, 16'($urandom), 1'b1);
        default: program_regs(16'($urandom), 16'($urandom_range(1, 65535)),
                              16'($urandom), p == 4);
      endcase
      idle_pct  = (p == 7) ? 0 : $urandom_range(0, 30);
      stall_pct = (p == 7) ? 0 : $urandom_range(0, 30);
      count     = (p == 2) ? 60 : 160;
      for (int i = 0; i < count; i++)
        send_with_gaps(random_item(sb.dist_limit, sb.centre_x));
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_cone_lane_steering_angle_core OK");
    else
      $display("tb_cone_lane_steering_angle_core NOT OK");
    $finish;
  end

endmodule
